// File: hw/rtl/rep_pkg.sv
// Package for the ring encoder positioner: ring constants, codes and payload types.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none
package rep_pkg;

   localparam int RING_STEPS = 96;
   localparam int POS_W      = 7;
   localparam int SPEED_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DIST_W     = 8;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(RING_STEPS - 1);

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_CLK  = 2'd1,
      EDGE_DT   = 2'd2,
      EDGE_RSVD = 2'd3
   } edge_kind_type;

   localparam logic [1:0] PINS_BOTH = 2'b11;
   localparam logic [1:0] PINS_CLK  = 2'b10;
   localparam logic [1:0] PINS_DT   = 2'b01;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_SPEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_SPEED  = 2'd2;

   localparam logic [SPEED_W-1:0] SLOW_SPEED_RST  = 8'd2;
   localparam logic [POS_W-1:0]   SLOW_WINDOW_RST = 7'd2;
   localparam logic [SPEED_W-1:0] HOME_SPEED_RST  = 8'd10;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   typedef struct packed {
      logic [1:0]         edge_kind;
      logic               clk_level;
      logic               dt_level;
      logic               limit_pressed;
      logic               start_move;
      logic [POS_W-1:0]   target;
      logic [SPEED_W-1:0] move_speed;
      logic               start_home;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic               is_homed;
      logic               motor_on;
      logic               motor_dir;
      logic [SPEED_W-1:0] motor_speed;
      logic               move_done;
   } rsp_type;

   typedef struct packed {
      logic [SPEED_W-1:0] slow_speed;
      logic [POS_W-1:0]   slow_window;
      logic [SPEED_W-1:0] home_speed;
   } cfg_type;

endpackage
`default_nettype wire

// File: hw/rtl/rep_if.sv
// Handshake channel interfaces of the ring encoder positioner: request, response, CSR write.
// Depends on rep_pkg for field widths.
`default_nettype none
interface rep_req_if import rep_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         edge_kind;
   logic               clk_level;
   logic               dt_level;
   logic               limit_pressed;
   logic               start_move;
   logic [POS_W-1:0]   target;
   logic [SPEED_W-1:0] move_speed;
   logic               start_home;

   modport source (output valid, edge_kind, clk_level, dt_level, limit_pressed,
                   start_move, target, move_speed, start_home, input ready);
   modport sink   (input valid, edge_kind, clk_level, dt_level, limit_pressed,
                   start_move, target, move_speed, start_home, output ready);
endinterface

interface rep_rsp_if import rep_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   position;
   logic               is_homed;
   logic               motor_on;
   logic               motor_dir;
   logic [SPEED_W-1:0] motor_speed;
   logic               move_done;

   modport source (output valid, position, is_homed, motor_on, motor_dir, motor_speed,
                   move_done, input ready);
   modport sink   (input valid, position, is_homed, motor_on, motor_dir, motor_speed,
                   move_done, output ready);
endinterface

interface rep_csr_if import rep_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rep_core.sv
// Positioner state and single-pass update: encoder decode, limit switch, commands, motion.
// Depends on rep_pkg; instantiated by ring_encoder_positioner_unit.
`default_nettype none
module rep_core import rep_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [POS_W-1:0]   ring_pos_ff, ring_pos_in;
   logic               clk_armed_ff, clk_armed_in;
   logic               dt_armed_ff, dt_armed_in;
   logic               homed_ff, homed_in;
   logic               moving_ff, moving_in;
   logic               homing_ff, homing_in;
   logic [POS_W-1:0]   goal_ff, goal_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               dir_ff, dir_in;

   logic [1:0]         pins;
   logic [POS_W-1:0]   pos_enc;
   logic               take_move;
   logic [DIST_W-1:0]  dist_up, dist_down;
   logic [POS_W-1:0]   diff;
   logic               done;

   always_comb begin
      pins         = {item.clk_level, item.dt_level};
      pos_enc      = ring_pos_ff;
      clk_armed_in = clk_armed_ff;
      dt_armed_in  = dt_armed_ff;
      case (edge_kind_type'(item.edge_kind))
         EDGE_CLK: begin
            if (pins == PINS_BOTH && clk_armed_ff) begin
               pos_enc      = (ring_pos_ff == '0) ? LAST_POS : ring_pos_ff - 1'b1;
               clk_armed_in = 1'b0;
               dt_armed_in  = 1'b0;
            end else if (pins == PINS_CLK) begin
               dt_armed_in = 1'b1;
            end
         end
         EDGE_DT: begin
            if (pins == PINS_BOTH && dt_armed_ff) begin
               pos_enc      = (ring_pos_ff >= LAST_POS) ? '0 : ring_pos_ff + 1'b1;
               clk_armed_in = 1'b0;
               dt_armed_in  = 1'b0;
            end else if (pins == PINS_DT) begin
               clk_armed_in = 1'b1;
            end
         end
         default: ;
      endcase

      ring_pos_in = pos_enc;
      homed_in    = homed_ff;
      homing_in   = homing_ff;
      done        = 1'b0;
      if (item.limit_pressed) begin
         ring_pos_in = '0;
         homed_in    = 1'b1;
         if (homing_ff) begin
            homing_in = 1'b0;
            done      = 1'b1;
         end
      end

      // shortest way on the ring; tie goes counterclockwise
      dist_up   = (item.target >= ring_pos_in)
                ? DIST_W'(item.target) - DIST_W'(ring_pos_in)
                : DIST_W'(item.target) + DIST_W'(RING_STEPS) - DIST_W'(ring_pos_in);
      dist_down = DIST_W'(RING_STEPS) - dist_up;
      take_move = item.start_move && (item.target <= LAST_POS)
                && (item.target != ring_pos_in);

      moving_in = moving_ff;
      goal_in   = goal_ff;
      speed_in  = speed_ff;
      dir_in    = dir_ff;
      if (take_move) begin
         dir_in    = (dist_up <= dist_down) ? DIR_CCW : DIR_CW;
         goal_in   = item.target;
         speed_in  = item.move_speed;
         moving_in = 1'b1;
         homing_in = 1'b0;
      end else if (item.start_home && !homed_in && !moving_ff && !homing_in) begin
         homing_in = 1'b1;
         dir_in    = DIR_CW;
         speed_in  = cfg.home_speed;
      end

      diff = (ring_pos_in > goal_in) ? ring_pos_in - goal_in : goal_in - ring_pos_in;
      result.motor_on    = 1'b0;
      result.motor_dir   = DIR_CW;
      result.motor_speed = '0;
      if (moving_in) begin
         if (ring_pos_in == goal_in) begin
            moving_in = 1'b0;
            done      = 1'b1;
         end else begin
            if (diff < cfg.slow_window && speed_in != '0) begin
               speed_in = cfg.slow_speed;
            end
            result.motor_on    = 1'b1;
            result.motor_dir   = dir_in;
            result.motor_speed = speed_in;
         end
      end else if (homing_in) begin
         result.motor_on    = 1'b1;
         result.motor_dir   = DIR_CW;
         result.motor_speed = speed_in;
      end
      result.position  = ring_pos_in;
      result.is_homed  = homed_in;
      result.move_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff  <= '0;
         clk_armed_ff <= 1'b0;
         dt_armed_ff  <= 1'b0;
         homed_ff     <= 1'b0;
         moving_ff    <= 1'b0;
         homing_ff    <= 1'b0;
         goal_ff      <= '0;
         speed_ff     <= '0;
         dir_ff       <= 1'b0;
      end else if (step) begin
         ring_pos_ff  <= ring_pos_in;
         clk_armed_ff <= clk_armed_in;
         dt_armed_ff  <= dt_armed_in;
         homed_ff     <= homed_in;
         moving_ff    <= moving_in;
         homing_ff    <= homing_in;
         goal_ff      <= goal_in;
         speed_ff     <= speed_in;
         dir_ff       <= dir_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ring_encoder_positioner_unit.sv
// Top level of the ring encoder positioner: request register, core update, response register, CSRs.
// Depends on rep_pkg, rep_if (channel interfaces) and rep_core.
//
// Usage:
//  - req: one request per encoder pin edge or control tick (edge, pin levels, limit
//    switch, move and home commands). Taken when req.valid and req.ready are high.
//  - rsp: exactly one response per request, in order: position, homed flag, motor
//    drive and a done pulse.
//  - csr: writes slow_speed (0), slow_window (1), home_speed (2); index 3 is ignored.
//    Always ready; write only while no request is in flight.
// Path: a request is registered in the request register, then the state update and
// response are computed combinationally from it into the response register, which
// drives rsp.valid.
// Throughput: one request per cycle while the response is taken; the state update is combinational.
// Stall: when rsp.ready is low the response holds; one more request may wait in
// the request register, then req.ready drops until the response is taken.
// Reset (synchronous, active high): ring position 0, not homed, motor off, both
// pipeline registers empty, CSRs to slow_speed 2, slow_window 2, home_speed 10.
`default_nettype none
module ring_encoder_positioner_unit import rep_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rep_req_if.sink   req,
   rep_rsp_if.source rsp,
   rep_csr_if.sink   csr
);

   req_type item_ff, item_in;
   logic    item_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   cfg_type cfg_ff;
   logic    step;

   assign step      = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || step;
   assign csr.ready = 1'b1;

   assign item_in = '{edge_kind:     req.edge_kind,
                      clk_level:     req.clk_level,
                      dt_level:      req.dt_level,
                      limit_pressed: req.limit_pressed,
                      start_move:    req.start_move,
                      target:        req.target,
                      move_speed:    req.move_speed,
                      start_home:    req.start_home};

   rep_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            item_valid_ff <= 1'b1;
         end else if (step) begin
            item_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_speed  <= SLOW_SPEED_RST;
         cfg_ff.slow_window <= SLOW_WINDOW_RST;
         cfg_ff.home_speed  <= HOME_SPEED_RST;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_SLOW_SPEED:  cfg_ff.slow_speed  <= csr.data;
            CSR_SLOW_WINDOW: cfg_ff.slow_window <= csr.data[POS_W-1:0];
            CSR_HOME_SPEED:  cfg_ff.home_speed  <= csr.data;
            default: ;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.position    = rsp_ff.position;
   assign rsp.is_homed    = rsp_ff.is_homed;
   assign rsp.motor_on    = rsp_ff.motor_on;
   assign rsp.motor_dir   = rsp_ff.motor_dir;
   assign rsp.motor_speed = rsp_ff.motor_speed;
   assign rsp.move_done   = rsp_ff.move_done;

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for ring_encoder_positioner_unit: queued request driver, response monitor and an
// in-bench positioner predictor, checked field by field. Depends on rep_pkg and rep_if.
module tb;
   import rep_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int REQ_W = $bits(req_type);

   typedef struct {
      logic [POS_W-1:0]   pos;
      bit                 clk_armed;
      bit                 dt_armed;
      bit                 homed;
      bit                 moving;
      bit                 homing;
      logic [POS_W-1:0]   goal;
      logic [SPEED_W-1:0] speed;
      logic               dir;
   } axis_state_type;

   logic clock;
   logic reset;

   rep_req_if req_bus ();
   rep_rsp_if rsp_bus ();
   rep_csr_if csr_bus ();

   ring_encoder_positioner_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   cfg_type        axis_cfg;
   axis_state_type gen_axis;
   axis_state_type live_axis;
   req_type        pending_requests[$];
   rsp_type        expected_drive[$];
   req_type        in_flight;
   rsp_type        got, want;
   bit             jitter_on;
   int             queued_count;
   int             accepted_count;
   int             checked_count;
   int             done_count;
   int             error_count;
   int             setting_count;

   function automatic rsp_type advance_positioner(inout axis_state_type s, input cfg_type c,
                                                  input req_type r);
      logic [1:0] pins;
      int         up_dist, down_dist, gap;
      rsp_type    o;
      pins = {r.clk_level, r.dt_level};
      o = '0;
      if (r.edge_kind == EDGE_CLK) begin
         if (pins == PINS_BOTH && s.clk_armed) begin
            s.pos = (s.pos == 0) ? LAST_POS : s.pos - 1'b1;
            s.clk_armed = 0;
            s.dt_armed = 0;
         end else if (pins == PINS_CLK) begin
            s.dt_armed = 1;
         end
      end else if (r.edge_kind == EDGE_DT) begin
         if (pins == PINS_BOTH && s.dt_armed) begin
            s.pos = (s.pos >= LAST_POS) ? '0 : s.pos + 1'b1;
            s.clk_armed = 0;
            s.dt_armed = 0;
         end else if (pins == PINS_DT) begin
            s.clk_armed = 1;
         end
      end
      if (r.limit_pressed) begin
         s.pos = '0;
         s.homed = 1;
         if (s.homing) begin
            s.homing = 0;
            o.move_done = 1'b1;
         end
      end
      if (r.start_move && r.target <= LAST_POS && r.target != s.pos) begin
         up_dist = (int'(r.target) + RING_STEPS - int'(s.pos)) % RING_STEPS;
         down_dist = (int'(s.pos) + RING_STEPS - int'(r.target)) % RING_STEPS;
         s.dir = (up_dist <= down_dist) ? DIR_CCW : DIR_CW;
         s.goal = r.target;
         s.speed = r.move_speed;
         s.moving = 1;
         s.homing = 0;
      end else if (r.start_home && !s.homed && !s.moving && !s.homing) begin
         s.homing = 1;
         s.dir = DIR_CW;
         s.speed = c.home_speed;
      end
      if (s.moving) begin
         if (s.pos == s.goal) begin
            s.moving = 0;
            o.move_done = 1'b1;
         end else begin
            gap = (s.pos > s.goal) ? int'(s.pos) - int'(s.goal) : int'(s.goal) - int'(s.pos);
            if (gap < int'(c.slow_window) && s.speed != 0) s.speed = c.slow_speed;
            o.motor_on = 1'b1;
            o.motor_dir = s.dir;
            o.motor_speed = s.speed;
         end
      end else if (s.homing) begin
         o.motor_on = 1'b1;
         o.motor_dir = DIR_CW;
         o.motor_speed = s.speed;
      end
      o.position = s.pos;
      o.is_homed = s.homed;
      return o;
   endfunction

   function automatic req_type make_req(edge_kind_type kind, logic clk_lvl, logic dt_lvl,
                                        logic limit, logic move, logic [POS_W-1:0] tgt,
                                        logic [SPEED_W-1:0] spd, logic home);
      req_type r;
      r.edge_kind = kind;
      r.clk_level = clk_lvl;
      r.dt_level = dt_lvl;
      r.limit_pressed = limit;
      r.start_move = move;
      r.target = tgt;
      r.move_speed = spd;
      r.start_home = home;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] expv,
                                  input logic [31:0] gotv);
      $display("MISMATCH %s: expected %0d got %0d at response %0d", what, expv, gotv,
               checked_count);
      error_count++;
   endtask

   task automatic queue_req(input req_type r);
      pending_requests.push_back(r);
      void'(advance_positioner(gen_axis, axis_cfg, r));
      queued_count++;
   endtask

   // one full detent: arm, then the stepping edge
   task automatic queue_step(input bit upward, input req_type base);
      req_type a, b;
      a = base;
      a.limit_pressed = 0;
      a.start_move = 0;
      a.start_home = 0;
      b = a;
      if (upward) begin
         a.edge_kind = EDGE_CLK;
         {a.clk_level, a.dt_level} = PINS_CLK;
         b.edge_kind = EDGE_DT;
      end else begin
         a.edge_kind = EDGE_DT;
         {a.clk_level, a.dt_level} = PINS_DT;
         b.edge_kind = EDGE_CLK;
      end
      {b.clk_level, b.dt_level} = PINS_BOTH;
      queue_req(a);
      queue_req(b);
   endtask

   task automatic finish_motion();
      while (gen_axis.moving) queue_step(gen_axis.dir == DIR_CCW, '0);
   endtask

   task automatic queue_random(input int count, input bit no_limit);
      req_type                r;
      logic [REQ_W-1:0]       raw;
      int                     pick, off;
      bit                     upward;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         r = '0;
         r.target = POS_W'($urandom_range(127));
         r.move_speed = SPEED_W'($urandom_range(255));
         if (pick < 50) begin
            if (gen_axis.moving && $urandom_range(9) < 8) upward = (gen_axis.dir == DIR_CCW);
            else upward = 1'($urandom_range(1));
            queue_step(upward, r);
         end else if (pick < 65) begin
            r.start_move = 1;
            case ($urandom_range(9))
               0: r.target = gen_axis.pos;
               1: r.target = POS_W'($urandom_range(127, RING_STEPS));
               2, 3, 4: begin
                  off = $urandom_range(1, 4);
                  if ($urandom_range(1)) off = -off;
                  r.target = POS_W'((int'(gen_axis.pos) + RING_STEPS + off) % RING_STEPS);
               end
               default: r.target = POS_W'($urandom_range(RING_STEPS - 1));
            endcase
            if ($urandom_range(9) == 0) r.move_speed = '0;
            r.start_home = ($urandom_range(3) == 0);
            queue_req(r);
         end else if (pick < 72) begin
            r.start_home = 1;
            queue_req(r);
         end else if (pick < 77 && !no_limit) begin
            r.limit_pressed = 1;
            r.edge_kind = 2'($urandom_range(3));
            r.clk_level = 1'($urandom_range(1));
            r.dt_level = 1'($urandom_range(1));
            queue_req(r);
         end else begin
            raw = REQ_W'($urandom());
            r = raw;
            if (no_limit) r.limit_pressed = 0;
            queue_req(r);
         end
      end
   endtask

   task automatic csr_program(input logic [CSR_DATA_W-1:0] ss, input logic [CSR_DATA_W-1:0] sw,
                              input logic [CSR_DATA_W-1:0] hs, input bit with_unused);
      logic [CSR_IDX_W-1:0]  idx_q[$];
      logic [CSR_DATA_W-1:0] dat_q[$];
      int                    n;
      if (with_unused) begin
         idx_q.push_back(CSR_UNUSED);
         dat_q.push_back(CSR_DATA_W'($urandom_range(255)));
      end
      idx_q.push_back(CSR_SLOW_SPEED);
      dat_q.push_back(ss);
      idx_q.push_back(CSR_SLOW_WINDOW);
      dat_q.push_back(sw);
      idx_q.push_back(CSR_HOME_SPEED);
      dat_q.push_back(hs);
      n = 0;
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx_q[0];
      csr_bus.data <= dat_q[0];
      while (n < idx_q.size()) begin
         @(posedge clock);
         if (csr_bus.ready) begin
            case (idx_q[n])
               CSR_SLOW_SPEED:  axis_cfg.slow_speed = dat_q[n];
               CSR_SLOW_WINDOW: axis_cfg.slow_window = dat_q[n][POS_W-1:0];
               CSR_HOME_SPEED:  axis_cfg.home_speed = dat_q[n];
               default: ;
            endcase
            n++;
            if (n < idx_q.size()) begin
               csr_bus.index <= idx_q[n];
               csr_bus.data <= dat_q[n];
            end else begin
               csr_bus.valid <= 1'b0;
            end
         end
      end
      setting_count++;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (accepted_count != queued_count || expected_drive.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_drive.push_back(advance_positioner(live_axis, axis_cfg, in_flight));
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && !(jitter_on && $urandom_range(99) < 20)) begin
               in_flight = pending_requests.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.edge_kind <= in_flight.edge_kind;
               req_bus.clk_level <= in_flight.clk_level;
               req_bus.dt_level <= in_flight.dt_level;
               req_bus.limit_pressed <= in_flight.limit_pressed;
               req_bus.start_move <= in_flight.start_move;
               req_bus.target <= in_flight.target;
               req_bus.move_speed <= in_flight.move_speed;
               req_bus.start_home <= in_flight.start_home;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.position = rsp_bus.position;
            got.is_homed = rsp_bus.is_homed;
            got.motor_on = rsp_bus.motor_on;
            got.motor_dir = rsp_bus.motor_dir;
            got.motor_speed = rsp_bus.motor_speed;
            got.move_done = rsp_bus.move_done;
            if (expected_drive.size() == 0) begin
               report_mismatch("response with nothing expected, position", 32'd0,
                               32'(got.position));
            end else begin
               want = expected_drive.pop_front();
               if (want.move_done) done_count++;
               if (got.position !== want.position)
                  report_mismatch("position", 32'(want.position), 32'(got.position));
               if (got.is_homed !== want.is_homed)
                  report_mismatch("is_homed", 32'(want.is_homed), 32'(got.is_homed));
               if (got.motor_on !== want.motor_on)
                  report_mismatch("motor_on", 32'(want.motor_on), 32'(got.motor_on));
               if (got.motor_dir !== want.motor_dir)
                  report_mismatch("motor_dir", 32'(want.motor_dir), 32'(got.motor_dir));
               if (got.motor_speed !== want.motor_speed)
                  report_mismatch("motor_speed", 32'(want.motor_speed), 32'(got.motor_speed));
               if (got.move_done !== want.move_done)
                  report_mismatch("move_done", 32'(want.move_done), 32'(got.move_done));
            end
            checked_count++;
         end
         rsp_bus.ready <= !(jitter_on && $urandom_range(99) < 20);
      end
   end

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1_600_000;
      $display("ring_encoder_positioner_unit verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.edge_kind = EDGE_NONE;
      req_bus.clk_level = 1'b0;
      req_bus.dt_level = 1'b0;
      req_bus.limit_pressed = 1'b0;
      req_bus.start_move = 1'b0;
      req_bus.target = '0;
      req_bus.move_speed = '0;
      req_bus.start_home = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      jitter_on = 1;
      queued_count = 0;
      accepted_count = 0;
      checked_count = 0;
      done_count = 0;
      error_count = 0;
      setting_count = 1;
      axis_cfg.slow_speed = SLOW_SPEED_RST;
      axis_cfg.slow_window = SLOW_WINDOW_RST;
      axis_cfg.home_speed = HOME_SPEED_RST;
      gen_axis = '{default: '0};
      live_axis = '{default: '0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: homing, wraps both ways, unarmed edges, bad targets, tie, slow-down
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_NONE, 1, 1, 0, 0, 7'd127, 8'd255, 1));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 1));
      queue_req(make_req(EDGE_DT, 0, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_CLK, 1, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_CLK, 1, 0, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_DT, 1, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_CLK, 1, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_DT, 1, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_RSVD, 1, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_RSVD, 0, 1, 0, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd127, 8'd99, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd96, 8'd99, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd0, 8'd99, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd48, 8'd255, 1));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd95, 8'd0, 0));
      queue_step(0, '0);
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd1, 8'd200, 0));
      queue_step(1, '0);
      queue_step(1, '0);
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 1));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd5, 8'd77, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 1));

      // keep the axis unhomed for a while so homing gets exercised
      queue_random(170, 1);
      finish_motion();
      if (!gen_axis.homing) queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 1));
      queue_step(1'($urandom_range(1)), '0);
      queue_req(make_req(EDGE_NONE, 0, 0, 1, 0, 7'd0, 8'd0, 0));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 0, 7'd0, 8'd0, 1));
      queue_req(make_req(EDGE_NONE, 0, 0, 0, 1, 7'd3, 8'd50, 0));
      queue_step(1, '0);
      queue_req(make_req(EDGE_NONE, 0, 0, 1, 0, 7'd0, 8'd0, 0));
      finish_motion();
      wait_drained();

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: csr_program(8'd255, 8'd95, 8'd255, 0);
            2: csr_program(8'd0, 8'd1, 8'd0, 0);
            3: csr_program(CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(1, 95)),
                           CSR_DATA_W'($urandom_range(255)), 1);
            4: csr_program(8'd7, 8'h80, 8'd200, 0);
            5: csr_program(8'd1, 8'hFF, 8'd3, 0);
            default: csr_program(SLOW_SPEED_RST, 8'd2, HOME_SPEED_RST, 0);
         endcase
         jitter_on = (phase != 3);
         queue_random(150, 0);
         wait_drained();
      end

      $display("Run covered %0d requests under %0d register settings, with encoder wraps,",
               accepted_count, setting_count);
      $display("homing, slow-downs and %0d finished moves; %0d responses compared.",
               done_count, checked_count);
      if (error_count == 0) begin
         $display("ring_encoder_positioner_unit verification clean");
      end else begin
         $display("ring_encoder_positioner_unit verification failed");
      end
      $finish;
   end
endmodule
